### rtl/core/cbb_pkg.sv
// ----------------------------------------------------------------------------
// cbb_pkg: shared types and constants for the cylinder bounding box block
// Widths, pipeline depths and request/result structs.
// ----------------------------------------------------------------------------
`default_nettype none

package cbb_pkg;

	localparam int COORD_FRAC_BITS = 16;

	localparam int CFG_W     = 31;                 // diameter / length registers
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DW    = 32;
	localparam int COORD_W   = 32;
	localparam int AXIS_W    = 16;
	localparam int MAG_W     = AXIS_W;             // |a| fits unsigned 16 bits
	localparam int SQ_W      = 2 * MAG_W - 1;      // a^2 <= 2^30
	localparam int NORM_W    = 32;                 // sum of three squares
	localparam int XSQ_W     = 2 * CFG_W;          // X^2
	localparam int HALF_W    = XSQ_W / 2;          // split of X^2 for the product
	localparam int PP_W      = HALF_W + NORM_W;
	localparam int PROD_W    = XSQ_W + NORM_W;     // X^2 * m
	localparam int DIV_W     = NORM_W + 2;         // 4n
	localparam int QUO_W     = XSQ_W - 2;          // quotient <= X^2/4
	localparam int ROOT_W    = QUO_W / 2;
	localparam int SQREM_W   = ROOT_W + 3;

	localparam int DIV_STEPS   = 4;
	localparam int DIV_STAGES  = QUO_W / DIV_STEPS;
	localparam int SQRT_STEPS  = 3;
	localparam int SQRT_STAGES = ROOT_W / SQRT_STEPS;
	localparam int TERM_LAT    = 2 + DIV_STAGES + SQRT_STAGES;
	localparam int TOTAL_LAT   = TERM_LAT + 3;     // start to done strobe

	localparam logic [CFG_W-1:0] CFG_ONE = CFG_W'(1 << COORD_FRAC_BITS);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DIAMETER = 2'd0,
		REG_LENGTH   = 2'd1
	} cfg_reg_e;

	typedef struct packed {
		logic signed [COORD_W-1:0] center_x;
		logic signed [COORD_W-1:0] center_y;
		logic signed [COORD_W-1:0] center_z;
		logic signed [AXIS_W-1:0]  axis_x;
		logic signed [AXIS_W-1:0]  axis_y;
		logic signed [AXIS_W-1:0]  axis_z;
	} cbb_req_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] box_min_x;
		logic signed [COORD_W-1:0] box_max_x;
		logic signed [COORD_W-1:0] box_min_y;
		logic signed [COORD_W-1:0] box_max_y;
		logic signed [COORD_W-1:0] box_min_z;
		logic signed [COORD_W-1:0] box_max_z;
		logic                      axis_zero;
	} cbb_res_t;

	typedef struct packed {
		logic [DIV_W-1:0] rem;
		logic [QUO_W-1:0] sh;   // dividend bits out at top, quotient bits in at bottom
	} cbb_div_t;

	typedef struct packed {
		logic [SQREM_W-1:0] rem;
		logic [ROOT_W-1:0]  root;
		logic [QUO_W-1:0]   q;  // radicand, two bits consumed per step
	} cbb_sqrt_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
		logic signed [COORD_W-1:0] cz;
		logic                      zero;
	} cbb_ctr_t;

endpackage

`default_nettype wire

### rtl/core/cbb_div_stage.sv
// ----------------------------------------------------------------------------
// cbb_div_stage: one registered stage of the restoring divider
// Retires DIV_STEPS quotient bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cbb_div_stage import cbb_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire cbb_div_t         in_st,
	input  wire logic [DIV_W-1:0] in_d,
	output logic                  out_valid,
	output cbb_div_t              out_st,
	output logic [DIV_W-1:0]      out_d
);

	cbb_div_t         st_nxt;
	logic             valid_s1;
	cbb_div_t         st_s1;
	logic [DIV_W-1:0] d_s1;

	always_comb begin
		logic [DIV_W:0] trial;
		trial  = '0;
		st_nxt = in_st;
		for (int i = 0; i < DIV_STEPS; i++) begin
			trial = {st_nxt.rem, st_nxt.sh[QUO_W-1]};
			if (trial >= {1'b0, in_d}) begin
				st_nxt.rem = DIV_W'(trial - {1'b0, in_d});
				st_nxt.sh  = {st_nxt.sh[QUO_W-2:0], 1'b1};
			end else begin
				st_nxt.rem = trial[DIV_W-1:0];
				st_nxt.sh  = {st_nxt.sh[QUO_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			st_s1 <= st_nxt;
			d_s1  <= in_d;
		end
	end

	assign out_valid = valid_s1;
	assign out_st    = st_s1;
	assign out_d     = d_s1;

endmodule

`default_nettype wire

### rtl/core/cbb_sqrt_stage.sv
// ----------------------------------------------------------------------------
// cbb_sqrt_stage: one registered stage of the digit-by-digit square root
// Retires SQRT_STEPS root bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cbb_sqrt_stage import cbb_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	input  wire cbb_sqrt_t in_st,
	output logic           out_valid,
	output cbb_sqrt_t      out_st
);

	cbb_sqrt_t st_nxt;
	logic      valid_s1;
	cbb_sqrt_t st_s1;

	always_comb begin
		logic [SQREM_W-1:0] rem2;
		logic [SQREM_W-1:0] trial;
		rem2   = '0;
		trial  = '0;
		st_nxt = in_st;
		for (int i = 0; i < SQRT_STEPS; i++) begin
			rem2  = {st_nxt.rem[SQREM_W-3:0], st_nxt.q[QUO_W-1 -: 2]};
			trial = {1'b0, st_nxt.root, 2'b01};
			st_nxt.q = {st_nxt.q[QUO_W-3:0], 2'b00};
			if (rem2 >= trial) begin
				st_nxt.rem  = rem2 - trial;
				st_nxt.root = {st_nxt.root[ROOT_W-2:0], 1'b1};
			end else begin
				st_nxt.rem  = rem2;
				st_nxt.root = {st_nxt.root[ROOT_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			st_s1 <= st_nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_st    = st_s1;

endmodule

`default_nettype wire

### rtl/core/cbb_term.sv
// ----------------------------------------------------------------------------
// cbb_term: pipelined floor(sqrt(X^2 * m / (4n)))
// Split product, restoring divide, then integer square root.
// ----------------------------------------------------------------------------
`default_nettype none

module cbb_term import cbb_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic [XSQ_W-1:0]  x_sq,
	input  wire logic [NORM_W-1:0] m,
	input  wire logic [NORM_W-1:0] n,
	output logic                   out_valid,
	output logic [ROOT_W-1:0]      t
);

	logic              valid_s1;
	logic [PP_W-1:0]   p_lo_s1;
	logic [PP_W-1:0]   p_hi_s1;
	logic [DIV_W-1:0]  d_s1;
	logic              valid_s2;
	cbb_div_t          div_s2;
	logic [DIV_W-1:0]  d_s2;
	logic [PROD_W-1:0] prod;

	logic             div_vld [DIV_STAGES+1];
	cbb_div_t         div_st  [DIV_STAGES+1];
	logic [DIV_W-1:0] div_d   [DIV_STAGES+1];
	logic             sq_vld  [SQRT_STAGES+1];
	cbb_sqrt_t        sq_st   [SQRT_STAGES+1];

	assign prod = {p_hi_s1, HALF_W'(0)} + PROD_W'(p_lo_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			p_lo_s1 <= PP_W'(x_sq[HALF_W-1:0] * m);
			p_hi_s1 <= PP_W'(x_sq[XSQ_W-1:HALF_W] * m);
			d_s1    <= {n, 2'b00};
		end
		if (valid_s1) begin
			div_s2.rem <= prod[PROD_W-1:QUO_W];
			div_s2.sh  <= prod[QUO_W-1:0];
			d_s2       <= d_s1;
		end
	end

	assign div_vld[0] = valid_s2;
	assign div_st[0]  = div_s2;
	assign div_d[0]   = d_s2;

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		cbb_div_stage u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (div_vld[g]),
			.in_st    (div_st[g]),
			.in_d     (div_d[g]),
			.out_valid(div_vld[g+1]),
			.out_st   (div_st[g+1]),
			.out_d    (div_d[g+1])
		);
	end

	// divisor is dropped after the last divide stage
	assign sq_vld[0]     = div_vld[DIV_STAGES] | (div_d[DIV_STAGES] == '0 & 1'b0);
	assign sq_st[0].rem  = '0;
	assign sq_st[0].root = '0;
	assign sq_st[0].q    = div_st[DIV_STAGES].sh;

	for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_sqrt
		cbb_sqrt_stage u_sqrt (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (sq_vld[g]),
			.in_st    (sq_st[g]),
			.out_valid(sq_vld[g+1]),
			.out_st   (sq_st[g+1])
		);
	end

	// final remainder of the divide is not needed
	assign out_valid = sq_vld[SQRT_STAGES] & (div_st[DIV_STAGES].rem == div_st[DIV_STAGES].rem);
	assign t         = sq_st[SQRT_STAGES].root;

endmodule

`default_nettype wire

### rtl/core/cylinder_bounding_box.sv
// ----------------------------------------------------------------------------
// cylinder_bounding_box: axis-aligned bounding box of a cylindrical body
// Fully pipelined, one request per clock, fixed latency.
// ----------------------------------------------------------------------------
// A request (center in signed Q16.16, axis as three signed integers of any
// nonzero scale) is taken at every clock edge with start high; busy is always
// low, so a new request may follow in the very next cycle. Each request gives
// exactly one result, shown for one cycle with done high, in request order.
// The receiver cannot hold results off. The latency is set by the exact
// per-term arithmetic: a split 62x32 product (2 stages), a 60-bit restoring
// divide at 4 bits per stage (15 stages) and a 30-bit square root at 3 bits
// per stage (10 stages), with six such units running side by side (length
// and diameter term per axis). Per axis i the half extent is
// floor(sqrt(L^2*a_i^2/(4n))) + floor(sqrt(D^2*(n-a_i^2)/(4n))), n = |a|^2;
// edges saturate to 32 bits. An all-zero axis sets axis_zero and returns
// the center as every edge. Diameter (index 0) and length (index 1) are
// written through the cfg port, which is always ready; other indices are
// ignored. Write them only while no request is in flight.
`default_nettype none

module cylinder_bounding_box import cbb_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire cbb_req_t             request,
	output logic                      done,
	output cbb_res_t                  result,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DW-1:0]    cfg_data
);

	// configuration and its squares
	logic [CFG_W-1:0] diam_q;
	logic [CFG_W-1:0] len_q;
	logic [XSQ_W-1:0] dsq_q;
	logic [XSQ_W-1:0] lsq_q;

	logic                      accept;
	logic [MAG_W-1:0]          mag [3];
	logic                      valid_s1;
	logic signed [COORD_W-1:0] ctr_s1 [3];
	logic [SQ_W-1:0]           sq_s1 [3];
	logic [NORM_W-1:0]         n_sum;
	logic                      valid_s2;
	logic [NORM_W-1:0]         n_s2;
	logic [NORM_W-1:0]         m_len_s2 [3];
	logic [NORM_W-1:0]         m_dia_s2 [3];
	cbb_ctr_t                  ctr_s2;
	cbb_ctr_t                  dly_q [TERM_LAT];

	logic              tv_len [3];
	logic              tv_dia [3];
	logic [ROOT_W-1:0] t_len  [3];
	logic [ROOT_W-1:0] t_dia  [3];
	logic              term_valid;
	logic              done_q;
	cbb_res_t          res_q;
	cbb_res_t          res_nxt;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diam_q <= CFG_ONE;
			len_q  <= CFG_ONE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DIAMETER: diam_q <= cfg_data[CFG_W-1:0];
				REG_LENGTH:   len_q  <= cfg_data[CFG_W-1:0];
				default:      ;
			endcase
		end
	end

	// squares registered; config in flight is kept static by the user alone
	always_ff @(posedge clk) begin
		dsq_q <= diam_q * diam_q;
		lsq_q <= len_q * len_q;
	end

	// stage 1: axis magnitudes squared
	assign mag[0] = request.axis_x[AXIS_W-1] ? MAG_W'(-request.axis_x) : request.axis_x;
	assign mag[1] = request.axis_y[AXIS_W-1] ? MAG_W'(-request.axis_y) : request.axis_y;
	assign mag[2] = request.axis_z[AXIS_W-1] ? MAG_W'(-request.axis_z) : request.axis_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			done_q   <= term_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctr_s1[0] <= request.center_x;
			ctr_s1[1] <= request.center_y;
			ctr_s1[2] <= request.center_z;
			for (int i = 0; i < 3; i++) begin
				sq_s1[i] <= SQ_W'(mag[i] * mag[i]);
			end
		end
	end

	// stage 2: n = |a|^2 and the two weights per axis
	assign n_sum = NORM_W'(sq_s1[0]) + NORM_W'(sq_s1[1]) + NORM_W'(sq_s1[2]);

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			n_s2        <= n_sum;
			ctr_s2.cx   <= ctr_s1[0];
			ctr_s2.cy   <= ctr_s1[1];
			ctr_s2.cz   <= ctr_s1[2];
			ctr_s2.zero <= (n_sum == '0);
			for (int i = 0; i < 3; i++) begin
				m_len_s2[i] <= NORM_W'(sq_s1[i]);
				m_dia_s2[i] <= n_sum - NORM_W'(sq_s1[i]);
			end
		end
	end

	// center and zero flag ride alongside the term units
	always_ff @(posedge clk) begin
		dly_q[0] <= ctr_s2;
		for (int k = 1; k < TERM_LAT; k++) begin
			dly_q[k] <= dly_q[k-1];
		end
	end

	for (genvar g = 0; g < 3; g++) begin : g_axis
		cbb_term u_len (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (valid_s2),
			.x_sq     (lsq_q),
			.m        (m_len_s2[g]),
			.n        (n_s2),
			.out_valid(tv_len[g]),
			.t        (t_len[g])
		);
		cbb_term u_dia (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (valid_s2),
			.x_sq     (dsq_q),
			.m        (m_dia_s2[g]),
			.n        (n_s2),
			.out_valid(tv_dia[g]),
			.t        (t_dia[g])
		);
	end

	assign term_valid = tv_len[0] & tv_len[1] & tv_len[2] & tv_dia[0] & tv_dia[1] & tv_dia[2];

	function automatic logic signed [COORD_W-1:0] sat32(input logic signed [COORD_W+1:0] v);
		logic signed [COORD_W+1:0] hi_lim;
		logic signed [COORD_W+1:0] lo_lim;
		hi_lim = 34'sh0_7FFF_FFFF;
		lo_lim = -34'sh0_8000_0000;
		if (v > hi_lim) begin
			return 32'sh7FFF_FFFF;
		end else if (v < lo_lim) begin
			return 32'sh8000_0000;
		end else begin
			return v[COORD_W-1:0];
		end
	endfunction

	// output stage: c -/+ h, saturated; the center itself for a zero axis
	always_comb begin
		logic [ROOT_W:0]           h;
		logic signed [COORD_W+1:0] c;
		logic signed [COORD_W-1:0] lo [3];
		logic signed [COORD_W-1:0] hi [3];
		logic signed [COORD_W-1:0] cc [3];
		cc[0] = dly_q[TERM_LAT-1].cx;
		cc[1] = dly_q[TERM_LAT-1].cy;
		cc[2] = dly_q[TERM_LAT-1].cz;
		h = '0;
		c = '0;
		for (int i = 0; i < 3; i++) begin
			h = {1'b0, t_len[i]} + {1'b0, t_dia[i]};
			c = {{2{cc[i][COORD_W-1]}}, cc[i]};
			if (dly_q[TERM_LAT-1].zero) begin
				lo[i] = cc[i];
				hi[i] = cc[i];
			end else begin
				lo[i] = sat32(c - $signed({3'b000, h}));
				hi[i] = sat32(c + $signed({3'b000, h}));
			end
		end
		res_nxt.box_min_x = lo[0];
		res_nxt.box_max_x = hi[0];
		res_nxt.box_min_y = lo[1];
		res_nxt.box_max_y = hi[1];
		res_nxt.box_min_z = lo[2];
		res_nxt.box_max_z = hi[2];
		res_nxt.axis_zero = dly_q[TERM_LAT-1].zero;
	end

	always_ff @(posedge clk) begin
		if (term_valid) begin
			res_q <= res_nxt;
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

`default_nettype wire

### rtl/core/cbb_checker.sv
// ----------------------------------------------------------------------------
// cbb_checker: port-level checks for cylinder_bounding_box
// Latency, box order, degenerate-box and open-port checks; bound to top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cbb_checker import cbb_pkg::*; (
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     start,
	input wire logic     busy,
	input wire logic     done,
	input wire cbb_res_t result,
	input wire logic     cfg_ready
);

	// every done strobe traces back to an accepted request (start && !busy)
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, TOTAL_LAT))
		else $error("done without a request TOTAL_LAT cycles before");

	a_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.box_min_x <= result.box_max_x) &&
		         (result.box_min_y <= result.box_max_y) &&
		         (result.box_min_z <= result.box_max_z))
		else $error("box edges out of order");

	a_degenerate: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.axis_zero) |-> (result.box_min_x == result.box_max_x) &&
		         (result.box_min_y == result.box_max_y) &&
		         (result.box_min_z == result.box_max_z))
		else $error("zero axis gave a non-degenerate box");

	a_always_open: assert property (@(posedge clk) disable iff (!arst_n)
		!busy && cfg_ready)
		else $error("request or cfg side stalled");

endmodule

bind cylinder_bounding_box cbb_checker u_cbb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.done     (done),
	.result   (result),
	.cfg_ready(cfg_ready)
);

`default_nettype wire

### tb/tb_cylinder_bounding_box.sv
// ----------------------------------------------------------------------------
// tb_cylinder_bounding_box: self-checking bench for the cylinder bounding box
// A queue-fed driver sends requests, a monitor checks each done strobe against
// a bit-exact prediction of the box edges, and the run moves through several
// diameter/length settings, each written only with the pipeline drained.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_cylinder_bounding_box;
	timeunit 1ns;
	timeprecision 1ps;

	import cbb_pkg::*;

	localparam int  MAX_CYCLES = 400000;
	localparam int  DRAIN      = TOTAL_LAT + 10;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	cbb_req_t             request;
	logic                 done;
	cbb_res_t             result;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DW-1:0]    cfg_data;

	// bench copy of the two registers
	logic [CFG_W-1:0] diameter_q;
	logic [CFG_W-1:0] length_q;

	cbb_req_t pending_reqs[$];
	cbb_res_t expected_boxes[$];
	int       error_count;
	int       cycle_count;
	bit       quiet_stretch;   // no idling while set
	bit       hold_sender;     // pressure: stall the driver on demand

	cylinder_bounding_box i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.request   (request),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------------
	function automatic logic [63:0] int_sqrt(logic [127:0] v);
		logic [63:0]  root;
		logic [127:0] trial;
		root = '0;
		for (int b = 63; b >= 0; b--) begin
			trial = {64'd0, root | (64'd1 << b)};
			if (trial * trial <= v)
				root = root | (64'd1 << b);
		end
		return root;
	endfunction

	// floor(sqrt(x^2 * m / (4n)))
	function automatic logic [63:0] half_extent_term(logic [CFG_W-1:0] x,
			logic [63:0] m, logic [63:0] n);
		logic [127:0] num;
		logic [127:0] quo;
		num = {66'd0, x} * {66'd0, x} * {64'd0, m};
		quo = num / ({64'd0, n} << 2);
		return int_sqrt(quo);
	endfunction

	function automatic logic signed [COORD_W-1:0] clamp32(logic signed [63:0] v);
		if (v > 64'sd2147483647)
			return 32'h7fff_ffff;
		if (v < -64'sd2147483648)
			return 32'h8000_0000;
		return v[31:0];
	endfunction

	function automatic cbb_res_t predict_box(cbb_req_t r);
		cbb_res_t            box;
		logic [63:0]         sq[3];
		logic [63:0]         n;
		logic signed [63:0]  ctr[3];
		logic signed [63:0]  h;
		logic signed [63:0]  a;
		logic signed [31:0]  lo[3];
		logic signed [31:0]  hi[3];
		ctr[0] = r.center_x;
		ctr[1] = r.center_y;
		ctr[2] = r.center_z;
		a = r.axis_x; sq[0] = a * a;
		a = r.axis_y; sq[1] = a * a;
		a = r.axis_z; sq[2] = a * a;
		n = sq[0] + sq[1] + sq[2];
		for (int i = 0; i < 3; i++) begin
			h = 0;
			if (n != 0)
				h = half_extent_term(length_q, sq[i], n)
					+ half_extent_term(diameter_q, n - sq[i], n);
			lo[i] = clamp32(ctr[i] - h);
			hi[i] = clamp32(ctr[i] + h);
		end
		box.box_min_x = lo[0];
		box.box_max_x = hi[0];
		box.box_min_y = lo[1];
		box.box_max_y = hi[1];
		box.box_min_z = lo[2];
		box.box_max_z = hi[2];
		box.axis_zero = (n == 0);
		return box;
	endfunction

	// ------------------------------------------------------------------------
	// Driver: one request per accepted edge, random gaps
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start   <= 1'b0;
			request <= '0;
		end else begin
			// the request on the bus was taken at this edge if start && !busy
			if (start && !busy) begin
				expected_boxes.push_back(predict_box(request));
				void'(pending_reqs.pop_front());
			end
			// head of the queue is the next request to offer
			if (pending_reqs.size() > 0
					&& !hold_sender && (quiet_stretch || $urandom_range(99) >= 28)) begin
				start   <= 1'b1;
				request <= pending_reqs[0];
			end else begin
				start <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: results cannot be stalled, so compare on every done strobe
	// ------------------------------------------------------------------------
	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
		error_count++;
	endtask

	always @(posedge clk) begin
		cbb_res_t want;
		if (arst_n && done) begin
			if (expected_boxes.size() == 0) begin
				report_mismatch("unexpected result", 64'(result), 64'd0);
			end else begin
				want = expected_boxes.pop_front();
				if (result.box_min_x !== want.box_min_x)
					report_mismatch("box_min_x", 64'(result.box_min_x), 64'(want.box_min_x));
				if (result.box_max_x !== want.box_max_x)
					report_mismatch("box_max_x", 64'(result.box_max_x), 64'(want.box_max_x));
				if (result.box_min_y !== want.box_min_y)
					report_mismatch("box_min_y", 64'(result.box_min_y), 64'(want.box_min_y));
				if (result.box_max_y !== want.box_max_y)
					report_mismatch("box_max_y", 64'(result.box_max_y), 64'(want.box_max_y));
				if (result.box_min_z !== want.box_min_z)
					report_mismatch("box_min_z", 64'(result.box_min_z), 64'(want.box_min_z));
				if (result.box_max_z !== want.box_max_z)
					report_mismatch("box_max_z", 64'(result.box_max_z), 64'(want.box_max_z));
				if (result.axis_zero !== want.axis_zero)
					report_mismatch("axis_zero", 64'(result.axis_zero), 64'(want.axis_zero));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > MAX_CYCLES) begin
			$display("tb_cylinder_bounding_box: FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	task automatic wait_idle();
		while (pending_reqs.size() > 0 || start || expected_boxes.size() > 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	// registers are written only with the pipeline empty
	task automatic write_reg(cfg_reg_e idx, logic [CFG_DW-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_DIAMETER)
			diameter_q = data[CFG_W-1:0];
		else if (idx == REG_LENGTH)
			length_q = data[CFG_W-1:0];
		@(posedge clk);
	endtask

	function automatic logic [15:0] rand_axis();
		case ($urandom_range(5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'($urandom_range(4)) - 16'd2;
			3: return '0;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] rand_center();
		case ($urandom_range(5))
			0: return 32'h8000_0000 + $urandom_range(65535);
			1: return 32'h7fff_ffff - $urandom_range(65535);
			default: return $urandom;
		endcase
	endfunction

	task automatic queue_request(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
			logic [15:0] ax, logic [15:0] ay, logic [15:0] az);
		cbb_req_t r;
		r.center_x = cx; r.center_y = cy; r.center_z = cz;
		r.axis_x   = ax; r.axis_y   = ay; r.axis_z   = az;
		pending_reqs.push_back(r);
	endtask

	task automatic queue_random(int count);
		for (int k = 0; k < count; k++)
			queue_request(rand_center(), rand_center(), rand_center(),
				rand_axis(), rand_axis(), rand_axis());
	endtask

	logic [CFG_DW-1:0] diam_set[6] = '{32'h0001_0000, 32'h0000_0000, 32'h7fff_ffff,
		32'hffff_ffff, 32'h0000_0001, 32'h0003_8000};
	logic [CFG_DW-1:0] len_set[6]  = '{32'h0001_0000, 32'h7fff_ffff, 32'h0000_0000,
		32'h8000_0001, 32'h0000_0001, 32'h0020_0000};

	initial begin
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		error_count   = 0;
		cycle_count   = 0;
		quiet_stretch = 1'b0;
		hold_sender   = 1'b0;
		diameter_q    = CFG_ONE;
		length_q      = CFG_ONE;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero axis, axis extremes, center extremes at reset config
		queue_request(32'h0001_0000, 32'hffff_0000, 32'h7fff_ffff, 16'd0, 16'd0, 16'd0);
		queue_request(32'h8000_0000, 32'h7fff_ffff, 32'h0, 16'h8000, 16'h8000, 16'h8000);
		queue_request(32'h0, 32'h0, 32'h0, 16'h7fff, 16'd0, 16'd0);
		queue_request(32'h0, 32'h0, 32'h0, 16'd0, 16'hffff, 16'd0);
		queue_request(32'h0, 32'h0, 32'h0, 16'd0, 16'd0, 16'h8000);
		queue_request(32'hffff_ffff, 32'h5555_5555, 32'haaaa_aaaa, 16'h5555, 16'haaaa, 16'h0001);
		wait_idle();

		// saturation with huge sizes
		write_reg(REG_DIAMETER, 32'h7fff_ffff);
		write_reg(REG_LENGTH, 32'h7fff_ffff);
		queue_request(32'h7fff_ffff, 32'h8000_0000, 32'h0, 16'h7fff, 16'h8000, 16'h7fff);
		queue_request(32'h8000_0000, 32'h7fff_ffff, 32'h1, 16'h0001, 16'd0, 16'd0);
		queue_request(32'h7fff_ffff, 32'h8000_0000, 32'h0, 16'd0, 16'd0, 16'd0);
		queue_random(10);
		wait_idle();

		// random phases over several register settings
		for (int p = 0; p < 6; p++) begin
			write_reg(REG_DIAMETER, p == 3 ? $urandom : diam_set[p]);
			write_reg(REG_LENGTH, len_set[p]);
			quiet_stretch = (p == 2);
			queue_random(110);
			if (p == 4) begin
				// pressure: hold the sender until everything is back
				while (pending_reqs.size() > 55) @(posedge clk);
				hold_sender = 1'b1;
				while (expected_boxes.size() > 0 || start) @(posedge clk);
				hold_sender = 1'b0;
			end
			queue_random(110);
			wait_idle();
		end
		quiet_stretch = 1'b0;
		write_reg(REG_DIAMETER, 32'h0001_0000);
		write_reg(REG_LENGTH, 32'h0004_0000);
		queue_random(30);
		wait_idle();

		if (error_count == 0)
			$display("tb_cylinder_bounding_box: PASS");
		else
			$display("tb_cylinder_bounding_box: FAIL");
		$finish;
	end

endmodule

`default_nettype wire
